/* rtl/nll_pkg.sv */
// ----------------------------------------------------------------------------
// nll_pkg - numeric literal lexer package
// Shared types, codes and the byte classifier for the literal scanner.
// ----------------------------------------------------------------------------
package nll_pkg;

   localparam int NLL_MAX_LEN    = 255;
   localparam int NLL_CMD_DEPTH  = 4;
   localparam int NLL_RSP_DEPTH  = 2;
   localparam int NLL_LEN_W      = 8;
   localparam int NLL_CLASS_W    = 3;

   typedef enum logic [NLL_CLASS_W-1:0] {
      CLS_DEC = 3'd0,
      CLS_BIN = 3'd1,
      CLS_HEX = 3'd2,
      CLS_FLT = 3'd3,
      CLS_BAD = 3'd4
   } token_class_type;

   typedef enum logic [3:0] {
      PH_START = 4'd0,
      PH_ZERO  = 4'd1,
      PH_BINP  = 4'd2,
      PH_BIN   = 4'd3,
      PH_HEXP  = 4'd4,
      PH_HEX   = 4'd5,
      PH_DEC   = 4'd6,
      PH_FRAC  = 4'd7,
      PH_EXP0  = 4'd8,
      PH_EXPS  = 4'd9,
      PH_EXPD  = 4'd10,
      PH_FSUF  = 4'd11,
      PH_ISUF  = 4'd12,
      PH_USUF  = 4'd13,
      PH_LSUF  = 4'd14,
      PH_DONE  = 4'd15
   } scan_phase_type;

   // decoded view of one source word
   typedef struct packed {
      logic eot;
      logic zero;
      logic bin_dig;
      logic dig;
      logic hex_dig;
      logic b;
      logic x;
      logic e;
      logic sign;
      logic dot;
      logic f;
      logic i;
      logic u;
      logic l;
      logic sep;
   } char_class_type;

   function automatic logic is_sep(logic [7:0] c);
      logic r;
      r = (c <= 8'h20);
      case (c)
         ",", ";", "+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|",
         "^", "(", ")", "[", "]", "{", "}", "~", "?", ":", ".": r = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic char_class_type classify(logic [7:0] c, logic eot);
      char_class_type r;
      r.eot     = eot;
      r.zero    = (c == "0");
      r.bin_dig = (c == "0") || (c == "1");
      r.dig     = (c >= "0") && (c <= "9");
      r.hex_dig = r.dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      r.b       = (c == "b") || (c == "B");
      r.x       = (c == "x") || (c == "X");
      r.e       = (c == "e") || (c == "E");
      r.sign    = (c == "+") || (c == "-");
      r.dot     = (c == ".");
      r.f       = (c == "f") || (c == "F");
      r.i       = (c == "i") || (c == "I");
      r.u       = (c == "u") || (c == "U");
      r.l       = (c == "l") || (c == "L");
      r.sep     = is_sep(c);
      return r;
   endfunction

endpackage

/* rtl/numeric_literal_lexer_unit.sv */
// ----------------------------------------------------------------------------
// numeric_literal_lexer_unit - numeric literal scanner
// Classifies a numeric literal as decimal, binary, hex, float or invalid.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_char_byte / req_end_of_text with req_push; a word
//   is taken on a clock edge with req_push high and req_full low. Feed the
//   literal from its first byte, then the first byte after it or an
//   end-of-text word. That closing word is consumed here but not counted.
//   Result queue: while rsp_empty is low, rsp_token_class/rsp_token_length
//   hold the oldest result; rsp_pop high takes it.
//   Throughput: one word per cycle while req_full is low. The decode stage
//   and the scan state machine are split by a 4-entry word queue; the scan
//   machine handles one word per cycle and stalls only when the 2-entry
//   result queue is full. A closing word is held in the word queue, scanned
//   once the result queue has room, and its result is written to that queue.
//   Reset (synchronous, active high) empties both queues and returns the
//   scanner to the start of a literal. A stalled result side fills the
//   result queue, then the word queue, then raises req_full; nothing is lost.
// ----------------------------------------------------------------------------
module numeric_literal_lexer_unit
   import nll_pkg::*;
#(
   parameter int MAX_LEN = NLL_MAX_LEN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [7:0]             req_char_byte,
   input  logic                   req_end_of_text,
   output logic                   req_full,
   input  logic                   rsp_pop,
   output logic [NLL_CLASS_W-1:0] rsp_token_class,
   output logic [NLL_LEN_W-1:0]   rsp_token_length,
   output logic                   rsp_empty
);

   localparam int CMD_W = $bits(char_class_type);
   localparam int RSP_W = NLL_CLASS_W + NLL_LEN_W;

   logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
   char_class_type        cmd_in, cmd_out;
   logic [CMD_W-1:0]      cmd_out_bits;
   logic                  res_push, res_full;
   token_class_type       res_class;
   logic [NLL_LEN_W-1:0]  res_length;
   logic [RSP_W-1:0]      res_bits;

   nll_front u_front (
      .push        (req_push),
      .char_byte   (req_char_byte),
      .end_of_text (req_end_of_text),
      .cmd_full    (cmd_full),
      .full        (req_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in)
   );

   nll_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (NLL_CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_bits),
      .empty     (cmd_empty)
   );

   assign cmd_out = char_class_type'(cmd_out_bits);

   nll_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_data   (cmd_out),
      .cmd_pop    (cmd_pop),
      .rsp_full   (res_full),
      .rsp_push   (res_push),
      .rsp_class  (res_class),
      .rsp_length (res_length)
   );

   nll_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (NLL_RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data ({res_class, res_length}),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_bits),
      .empty     (rsp_empty)
   );

   assign rsp_token_class  = res_bits[RSP_W-1:NLL_LEN_W];
   assign rsp_token_length = res_bits[NLL_LEN_W-1:0];

endmodule

/* rtl/nll_fifo.sv */
// ----------------------------------------------------------------------------
// nll_fifo - small synchronous word queue
// Flop-based queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module nll_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

/* rtl/nll_front.sv */
// ----------------------------------------------------------------------------
// nll_front - byte decode stage
// Turns each accepted source word into its character-class flags.
// ----------------------------------------------------------------------------
module nll_front
   import nll_pkg::*;
(
   input  logic           push,
   input  logic [7:0]     char_byte,
   input  logic           end_of_text,
   input  logic           cmd_full,
   output logic           full,
   output logic           cmd_push,
   output char_class_type cmd_data
);

   assign full     = cmd_full;
   assign cmd_push = push && !cmd_full;
   assign cmd_data = classify(char_byte, end_of_text);

endmodule

/* rtl/nll_back.sv */
// ----------------------------------------------------------------------------
// nll_back - literal scan state machine
// Steps the scan phase per decoded word and emits class and length.
// ----------------------------------------------------------------------------
module nll_back
   import nll_pkg::*;
#(
   parameter int MAX_LEN = NLL_MAX_LEN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  char_class_type         cmd_data,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output token_class_type        rsp_class,
   output logic [NLL_LEN_W-1:0]   rsp_length
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int LW    = (CNT_W > NLL_LEN_W) ? CNT_W : NLL_LEN_W;

   typedef struct packed {
      logic           ok;
      scan_phase_type phase;
      logic           to_flt;
   } step_type;

   scan_phase_type  phase_ff, phase_in;
   token_class_type class_ff, class_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   step_type        nx;
   logic            fire, missing, bad;
   logic [LW-1:0]   cnt_wide;

   function automatic step_type sfx(char_class_type c);
      step_type r;
      r = '{ok: 1'b1, phase: PH_FSUF, to_flt: 1'b1};
      if (c.f) r.phase = PH_FSUF;
      else if (c.i) r.phase = PH_ISUF;
      else r = '{ok: 1'b0, phase: PH_START, to_flt: 1'b0};
      return r;
   endfunction

   function automatic step_type exp_sfx(char_class_type c);
      step_type r;
      if (c.e) r = '{ok: 1'b1, phase: PH_EXP0, to_flt: 1'b0};
      else r = sfx(c);
      return r;
   endfunction

   function automatic step_type int_sfx(char_class_type c);
      step_type r;
      r = '{ok: 1'b0, phase: PH_START, to_flt: 1'b0};
      if (c.u) r = '{ok: 1'b1, phase: PH_USUF, to_flt: 1'b0};
      else if (c.l) r = '{ok: 1'b1, phase: PH_LSUF, to_flt: 1'b0};
      return r;
   endfunction

   function automatic step_type dec_step(char_class_type c);
      step_type r;
      if (c.dig) r = '{ok: 1'b1, phase: PH_DEC, to_flt: 1'b0};
      else if (c.dot) r = '{ok: 1'b1, phase: PH_FRAC, to_flt: 1'b1};
      else begin
         r = exp_sfx(c);
         if (!r.ok) r = int_sfx(c);
      end
      return r;
   endfunction

   always_comb begin
      nx = '{ok: 1'b0, phase: PH_START, to_flt: 1'b0};
      case (phase_ff)
         PH_START: begin
            if (cmd_data.zero) nx = '{ok: 1'b1, phase: PH_ZERO, to_flt: 1'b0};
            else nx = dec_step(cmd_data);
         end
         PH_ZERO: begin
            if (cmd_data.b) nx = '{ok: 1'b1, phase: PH_BINP, to_flt: 1'b0};
            else if (cmd_data.x) nx = '{ok: 1'b1, phase: PH_HEXP, to_flt: 1'b0};
            else nx = dec_step(cmd_data);
         end
         PH_DEC: nx = dec_step(cmd_data);
         PH_BINP, PH_BIN: begin
            if (cmd_data.bin_dig) nx = '{ok: 1'b1, phase: PH_BIN, to_flt: 1'b0};
            else if (phase_ff == PH_BIN) nx = int_sfx(cmd_data);
         end
         PH_HEXP, PH_HEX: begin
            if (cmd_data.hex_dig) nx = '{ok: 1'b1, phase: PH_HEX, to_flt: 1'b0};
            else if (phase_ff == PH_HEX) nx = int_sfx(cmd_data);
         end
         PH_FRAC: begin
            if (cmd_data.dig) nx = '{ok: 1'b1, phase: PH_FRAC, to_flt: 1'b0};
            else nx = exp_sfx(cmd_data);
         end
         PH_EXP0: begin
            if (cmd_data.sign) nx = '{ok: 1'b1, phase: PH_EXPS, to_flt: 1'b0};
            else if (cmd_data.dig) nx = '{ok: 1'b1, phase: PH_EXPD, to_flt: 1'b1};
         end
         PH_EXPS: begin
            if (cmd_data.dig) nx = '{ok: 1'b1, phase: PH_EXPD, to_flt: 1'b1};
         end
         PH_EXPD: begin
            if (cmd_data.dig) nx = '{ok: 1'b1, phase: PH_EXPD, to_flt: 1'b0};
            else nx = sfx(cmd_data);
         end
         PH_FSUF: begin
            if (cmd_data.i) nx = '{ok: 1'b1, phase: PH_ISUF, to_flt: 1'b0};
         end
         PH_USUF: begin
            if (cmd_data.l) nx = '{ok: 1'b1, phase: PH_DONE, to_flt: 1'b0};
         end
         PH_LSUF: begin
            if (cmd_data.u) nx = '{ok: 1'b1, phase: PH_DONE, to_flt: 1'b0};
         end
         default: nx = '{ok: 1'b0, phase: PH_START, to_flt: 1'b0};
      endcase
      if (cmd_data.eot) nx.ok = 1'b0;
   end

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;
   assign missing = (phase_ff == PH_BINP) || (phase_ff == PH_HEXP) ||
                    (phase_ff == PH_EXP0) || (phase_ff == PH_EXPS);
   assign bad     = missing || ovf_ff || (!cmd_data.eot && !cmd_data.sep);
   assign cnt_wide = LW'(count_ff);

   always_comb begin
      phase_in   = phase_ff;
      class_in   = class_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      rsp_push   = 1'b0;
      rsp_class  = bad ? CLS_BAD : class_ff;
      rsp_length = (cnt_wide > LW'(255)) ? NLL_LEN_W'(255) : cnt_wide[NLL_LEN_W-1:0];
      if (fire) begin
         if (nx.ok) begin
            phase_in = nx.phase;
            if (nx.to_flt) class_in = CLS_FLT;
            else if (nx.phase == PH_BIN) class_in = CLS_BIN;
            else if (nx.phase == PH_HEX) class_in = CLS_HEX;
            if (count_ff < CNT_W'(MAX_LEN)) count_in = count_ff + 1'b1;
            else ovf_in = 1'b1;
         end else begin
            rsp_push = 1'b1;
            phase_in = PH_START;
            class_in = CLS_DEC;
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         class_ff <= CLS_DEC;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_W'(MAX_LEN)))
      else $error("overflow without saturated count");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (phase_ff == PH_START) && (count_ff == '0) && !ovf_ff)
      else $error("scan state not cleared after result");

   a_hex_phase: assert property (@(posedge clock) disable iff (reset)
      (class_ff == CLS_HEX) |-> (phase_ff == PH_HEX || phase_ff == PH_USUF ||
                                 phase_ff == PH_LSUF || phase_ff == PH_DONE))
      else $error("hex class outside hex phases");

endmodule
